/* sv/tsot_pkg.sv */
`default_nettype none
package tsot_pkg;

  // Grid size defaults
  localparam int DEF_MAX_TIMESLOTS = 8;
  localparam int DEF_MAX_FREQSLOTS = 8;

  // Field widths
  localparam int CFG_W     = 4;   // grid size register
  localparam int GRID_W    = 5;   // effective grid size, up to 15
  localparam int TF_W      = 4;   // slot coordinate carried in a command
  localparam int IDX_IN_W  = 8;
  localparam int IDX_OUT_W = 3;
  localparam int NOW_W     = 63;
  localparam int TMO_W     = 32;
  localparam int MS_W      = 20;
  localparam int LIMIT_W   = 52;  // timeout in ns
  localparam int DIFF_W    = 64;
  localparam int HIT_W     = 7;
  localparam int RESULT_LIMIT = 64;

  localparam logic [MS_W-1:0] NS_PER_MS = 20'd1000000;

  // Stream and register port widths
  localparam int S_DATA_W = 112;
  localparam int S_USER_W = 4;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 1;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Register index, decoded from paddr[2]
  localparam logic REG_TIMESLOTS = 1'b0;
  localparam logic REG_FREQSLOTS = 1'b1;

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  typedef enum logic [3:0] {
    OP_USED    = 4'd0,
    OP_USED_TX = 4'd1,
    OP_USED_RX = 4'd2,
    OP_FREE    = 4'd3,
    OP_FREE_TX = 4'd4,
    OP_FREE_RX = 4'd5,
    OP_SCAN    = 4'd6,
    OP_SCAN_TX = 4'd7,
    OP_SCAN_RX = 4'd8,
    OP_CLEAR   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_USED = 2'd1,
    ST_TX   = 2'd2,
    ST_RX   = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    K_MARK,
    K_SCAN,
    K_CLEAR,
    K_NOP,
    K_OOR
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MARK,
    B_SCAN,
    B_END
  } back_st_t;

  // Classified item handed from front to back
  typedef struct packed {
    kind_t               kind;
    op_t                 op;
    logic [TF_W-1:0]     t;
    logic [TF_W-1:0]     f;
    logic [NOW_W-1:0]    now;
    logic [LIMIT_W-1:0]  limit;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           prior;
    logic                 changed;
    logic                 oor;
    logic                 idle_valid;
    logic [IDX_OUT_W-1:0] idle_t;
    logic [IDX_OUT_W-1:0] idle_f;
    logic                 last;
  } result_t;

  // Effective grid size: register clipped to the built maximum
  function automatic logic [GRID_W-1:0] grid_size(input logic [CFG_W-1:0] r, input int mx);
    logic [GRID_W-1:0] rx;
    logic [GRID_W-1:0] mxv;
    rx  = GRID_W'(r);
    mxv = GRID_W'(mx);
    return (rx < mxv) ? rx : mxv;
  endfunction

endpackage
`default_nettype wire

/* sv/tsot_front.sv */
`default_nettype none
module tsot_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [tsot_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic [tsot_pkg::S_USER_W-1:0]  s_tuser,
  input  wire logic [tsot_pkg::GRID_W-1:0]    grid_t,
  input  wire logic [tsot_pkg::GRID_W-1:0]    grid_f,
  output logic                                q_push,
  output tsot_pkg::cmd_t                      q_cmd,
  input  wire logic                           q_full
);
  import tsot_pkg::*;

  logic                 f_valid;
  logic [3:0]           f_op;
  logic [IDX_IN_W-1:0]  f_ti;
  logic [IDX_IN_W-1:0]  f_fi;
  logic [NOW_W-1:0]     f_now;
  logic [TMO_W-1:0]     f_tmo;
  logic                 in_grid;

  assign q_push   = f_valid && !q_full;
  assign s_tready = !f_valid || !q_full;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      f_op  <= s_tuser;
      f_ti  <= s_tdata[7:0];
      f_fi  <= s_tdata[15:8];
      f_now <= s_tdata[78:16];
      f_tmo <= s_tdata[110:79];
    end
  end

  // Classify; timeout scaled to ns lands in the queue register
  assign in_grid = (f_ti < IDX_IN_W'(grid_t)) && (f_fi < IDX_IN_W'(grid_f));

  always_comb begin
    q_cmd.kind  = K_NOP;
    q_cmd.op    = OP_CLEAR;
    q_cmd.t     = f_ti[TF_W-1:0];
    q_cmd.f     = f_fi[TF_W-1:0];
    q_cmd.now   = f_now;
    q_cmd.limit = LIMIT_W'(f_tmo) * LIMIT_W'(NS_PER_MS);
    unique case (f_op)
      OP_USED, OP_USED_TX, OP_USED_RX, OP_FREE, OP_FREE_TX, OP_FREE_RX: begin
        q_cmd.kind = in_grid ? K_MARK : K_OOR;
        q_cmd.op   = op_t'(f_op);
      end
      OP_SCAN, OP_SCAN_TX, OP_SCAN_RX: begin
        q_cmd.kind = K_SCAN;
        q_cmd.op   = op_t'(f_op);
      end
      OP_CLEAR: begin
        q_cmd.kind = K_CLEAR;
      end
      default: begin
        q_cmd.kind = K_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/tsot_fifo.sv */
`default_nettype none
module tsot_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  tsot_pkg::cmd_t       push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output tsot_pkg::cmd_t       head,
  output logic                 empty
);
  import tsot_pkg::*;

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (Q_PTR_W+1)'(1);
        2'b01:   count <= count - (Q_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

/* sv/tsot_back.sv */
`default_nettype none
module tsot_back #(
  parameter int MAX_TIMESLOTS = tsot_pkg::DEF_MAX_TIMESLOTS,
  parameter int MAX_FREQSLOTS = tsot_pkg::DEF_MAX_FREQSLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [tsot_pkg::GRID_W-1:0]  grid_t,
  input  wire logic [tsot_pkg::GRID_W-1:0]  grid_f,
  input  wire logic                         q_empty,
  input  tsot_pkg::cmd_t                    q_head,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output tsot_pkg::result_t                 res
);
  import tsot_pkg::*;

  localparam int SLOTS  = MAX_TIMESLOTS * MAX_FREQSLOTS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int T_W    = (MAX_TIMESLOTS > 1) ? $clog2(MAX_TIMESLOTS) : 1;
  localparam int F_W    = (MAX_FREQSLOTS > 1) ? $clog2(MAX_FREQSLOTS) : 1;

  function automatic logic [SLOT_W-1:0] slot_idx(input logic [T_W-1:0] t,
                                                 input logic [F_W-1:0] f);
    return SLOT_W'(t) * SLOT_W'(MAX_FREQSLOTS) + SLOT_W'(f);
  endfunction

  // Slot memories; valid bits stand in for the reset contents
  logic [1:0]       st_mem  [SLOTS];
  logic [NOW_W-1:0] gen_mem [SLOTS];
  logic [NOW_W-1:0] tx_mem  [SLOTS];
  logic [NOW_W-1:0] rx_mem  [SLOTS];
  logic [SLOTS-1:0] st_vld, gen_vld, tx_vld, rx_vld;

  logic [1:0]       rd_st;
  logic [NOW_W-1:0] rd_gen, rd_tx, rd_rx;
  logic             rd_st_v, rd_gen_v, rd_tx_v, rd_rx_v;

  // Control registers
  back_st_t          state, state_next;
  cmd_t              cur;
  logic              cur_load;
  logic              iss_active, iss_active_next;
  logic [T_W-1:0]    it_t, it_t_next;
  logic [F_W-1:0]    it_f, it_f_next;
  logic              s1_valid, s1_valid_next;
  logic [T_W-1:0]    s1_t, s1_t_next;
  logic [F_W-1:0]    s1_f, s1_f_next;
  logic              s1_end, s1_end_next;
  logic              pend_valid, pend_valid_next;
  logic [T_W-1:0]    pend_t, pend_t_next;
  logic [F_W-1:0]    pend_f, pend_f_next;
  logic [HIT_W-1:0]  hit_cnt, hit_cnt_next;
  logic              out_valid;
  result_t           out_res;

  // Datapath signals
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic [1:0]        st_wdata;
  logic              st_set, st_clr, gen_set, gen_clr, tx_set, tx_clr, rx_set, rx_clr;
  slot_st_t          s1_st;
  slot_st_t          ns;
  logic              chg;
  logic              in_use;
  logic [NOW_W-1:0]  stamp;
  logic [DIFF_W-1:0] diff;
  logic              s1_hit;
  logic              advance;
  logic              out_free;
  logic              emit;
  result_t           emit_res;
  logic              grid_empty;
  logic              iss_end;

  assign m_tvalid   = out_valid;
  assign res        = out_res;
  assign out_free   = !out_valid || m_tready;
  assign grid_empty = (grid_t == '0) || (grid_f == '0);
  assign iss_end    = (GRID_W'(it_t) == grid_t - GRID_W'(1)) &&
                      (GRID_W'(it_f) == grid_f - GRID_W'(1));
  assign s1_st      = rd_st_v ? slot_st_t'(rd_st) : ST_FREE;

  // Idle test for the slot in the read stage
  always_comb begin
    unique case (cur.op)
      OP_SCAN_TX: begin
        in_use = (s1_st == ST_USED) || (s1_st == ST_TX);
        stamp  = rd_tx_v ? rd_tx : '0;
      end
      OP_SCAN_RX: begin
        in_use = (s1_st == ST_USED) || (s1_st == ST_RX);
        stamp  = rd_rx_v ? rd_rx : '0;
      end
      default: begin
        in_use = (s1_st != ST_FREE);
        stamp  = rd_gen_v ? rd_gen : '0;
      end
    endcase
    diff   = DIFF_W'(cur.now) - DIFF_W'(stamp);
    s1_hit = (state == B_SCAN) && (cur.kind == K_SCAN) && s1_valid && in_use &&
             (diff >= DIFF_W'(cur.limit)) && (hit_cnt < HIT_W'(RESULT_LIMIT));
  end

  // Slot state transitions for mark operations
  always_comb begin
    ns      = s1_st;
    chg     = 1'b0;
    gen_set = 1'b0;
    gen_clr = 1'b0;
    tx_set  = 1'b0;
    tx_clr  = 1'b0;
    rx_set  = 1'b0;
    rx_clr  = 1'b0;
    unique case (cur.op)
      OP_USED: begin
        ns      = ST_USED;
        chg     = (s1_st == ST_FREE);
        gen_set = 1'b1;
      end
      OP_USED_TX: begin
        if (s1_st == ST_FREE) begin
          ns  = ST_TX;
          chg = 1'b1;
        end else if (s1_st == ST_RX) begin
          ns  = ST_USED;
          chg = 1'b1;
        end
        tx_set = 1'b1;
      end
      OP_USED_RX: begin
        if (s1_st == ST_FREE) begin
          ns  = ST_RX;
          chg = 1'b1;
        end else if (s1_st == ST_TX) begin
          ns  = ST_USED;
          chg = 1'b1;
        end
        rx_set = 1'b1;
      end
      OP_FREE: begin
        ns      = ST_FREE;
        chg     = (s1_st == ST_USED);
        gen_clr = 1'b1;
      end
      OP_FREE_TX: begin
        if (s1_st == ST_USED) begin
          ns  = ST_RX;
          chg = 1'b1;
        end else if (s1_st == ST_TX) begin
          ns  = ST_FREE;
          chg = 1'b1;
        end
        tx_clr = 1'b1;
      end
      OP_FREE_RX: begin
        if (s1_st == ST_USED) begin
          ns  = ST_TX;
          chg = 1'b1;
        end else if (s1_st == ST_RX) begin
          ns  = ST_FREE;
          chg = 1'b1;
        end
        rx_clr = 1'b1;
      end
      default: begin
        ns = s1_st;
      end
    endcase
  end

  // Sequencer: next state, memory strobes and result emission
  always_comb begin
    state_next      = state;
    q_pop           = 1'b0;
    cur_load        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = slot_idx(T_W'(q_head.t), F_W'(q_head.f));
    wr_addr         = slot_idx(s1_t, s1_f);
    st_wdata        = ns;
    st_set          = 1'b0;
    st_clr          = 1'b0;
    iss_active_next = iss_active;
    it_t_next       = it_t;
    it_f_next       = it_f;
    s1_valid_next   = s1_valid;
    s1_t_next       = s1_t;
    s1_f_next       = s1_f;
    s1_end_next     = s1_end;
    pend_valid_next = pend_valid;
    pend_t_next     = pend_t;
    pend_f_next     = pend_f;
    hit_cnt_next    = hit_cnt;
    advance         = 1'b0;
    emit            = 1'b0;
    emit_res        = '0;
    emit_res.last   = 1'b1;

    unique case (state)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop    = 1'b1;
          cur_load = 1'b1;
          unique case (q_head.kind)
            K_MARK: begin
              rd_en      = 1'b1;
              state_next = B_MARK;
            end
            K_SCAN, K_CLEAR: begin
              hit_cnt_next    = '0;
              pend_valid_next = 1'b0;
              s1_valid_next   = 1'b0;
              if (grid_empty) begin
                state_next = B_END;
              end else begin
                iss_active_next = 1'b1;
                it_t_next       = '0;
                it_f_next       = '0;
                state_next      = B_SCAN;
              end
            end
            K_OOR: begin
              emit         = 1'b1;
              emit_res.oor = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      B_MARK: begin
        // read data arrived last cycle; output register is empty here
        wr_addr          = slot_idx(T_W'(cur.t), F_W'(cur.f));
        st_set           = 1'b1;
        emit             = 1'b1;
        emit_res.prior   = s1_st;
        emit_res.changed = chg;
        state_next       = B_IDLE;
      end

      B_SCAN: begin
        advance = !(s1_hit && pend_valid && !out_free);
        if (advance) begin
          // issue stage
          if (iss_active) begin
            rd_en         = 1'b1;
            rd_addr       = slot_idx(it_t, it_f);
            s1_valid_next = 1'b1;
            s1_t_next     = it_t;
            s1_f_next     = it_f;
            s1_end_next   = iss_end;
            if (iss_end) begin
              iss_active_next = 1'b0;
            end else if (GRID_W'(it_f) == grid_f - GRID_W'(1)) begin
              it_f_next = '0;
              it_t_next = it_t + T_W'(1);
            end else begin
              it_f_next = it_f + F_W'(1);
            end
          end else begin
            s1_valid_next = 1'b0;
          end
          // read stage
          if (s1_valid) begin
            if (cur.kind == K_CLEAR && s1_st != ST_FREE) begin
              st_clr = 1'b1;
            end
            if (s1_hit) begin
              if (pend_valid) begin
                emit                = 1'b1;
                emit_res.idle_valid = 1'b1;
                emit_res.idle_t     = IDX_OUT_W'(pend_t);
                emit_res.idle_f     = IDX_OUT_W'(pend_f);
                emit_res.last       = 1'b0;
              end
              pend_valid_next = 1'b1;
              pend_t_next     = s1_t;
              pend_f_next     = s1_f;
              hit_cnt_next    = hit_cnt + HIT_W'(1);
            end
            if (s1_end) begin
              state_next = B_END;
            end
          end
        end
      end

      B_END: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid) begin
            emit_res.idle_valid = 1'b1;
            emit_res.idle_t     = IDX_OUT_W'(pend_t);
            emit_res.idle_f     = IDX_OUT_W'(pend_f);
          end
          pend_valid_next = 1'b0;
          state_next      = B_IDLE;
        end
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      iss_active <= 1'b0;
      it_t       <= '0;
      it_f       <= '0;
      s1_valid   <= 1'b0;
      s1_end     <= 1'b0;
      pend_valid <= 1'b0;
      hit_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      iss_active <= iss_active_next;
      it_t       <= it_t_next;
      it_f       <= it_f_next;
      s1_valid   <= s1_valid_next;
      s1_end     <= s1_end_next;
      pend_valid <= pend_valid_next;
      hit_cnt    <= hit_cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cur_load) cur <= q_head;
    if (emit) out_res <= emit_res;
    s1_t   <= s1_t_next;
    s1_f   <= s1_f_next;
    pend_t <= pend_t_next;
    pend_f <= pend_f_next;
  end

  // Memory read port and write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_st    <= st_mem[rd_addr];
      rd_gen   <= gen_mem[rd_addr];
      rd_tx    <= tx_mem[rd_addr];
      rd_rx    <= rx_mem[rd_addr];
      rd_st_v  <= st_vld[rd_addr];
      rd_gen_v <= gen_vld[rd_addr];
      rd_tx_v  <= tx_vld[rd_addr];
      rd_rx_v  <= rx_vld[rd_addr];
    end
    if (st_set) st_mem[wr_addr] <= st_wdata;
    if (state == B_MARK && gen_set) gen_mem[wr_addr] <= cur.now;
    if (state == B_MARK && tx_set)  tx_mem[wr_addr]  <= cur.now;
    if (state == B_MARK && rx_set)  rx_mem[wr_addr]  <= cur.now;
  end

  // Valid bits: a cleared bit reads as free state or zero stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld  <= '0;
      gen_vld <= '0;
      tx_vld  <= '0;
      rx_vld  <= '0;
    end else if (state == B_MARK) begin
      st_vld[wr_addr] <= 1'b1;
      if (gen_set) gen_vld[wr_addr] <= 1'b1;
      if (gen_clr) gen_vld[wr_addr] <= 1'b0;
      if (tx_set)  tx_vld[wr_addr]  <= 1'b1;
      if (tx_clr)  tx_vld[wr_addr]  <= 1'b0;
      if (rx_set)  rx_vld[wr_addr]  <= 1'b1;
      if (rx_clr)  rx_vld[wr_addr]  <= 1'b0;
    end else if (st_clr) begin
      st_vld[wr_addr]  <= 1'b0;
      gen_vld[wr_addr] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* sv/tdma_slot_occupancy_table_unit.sv */
// Channel   | Signals                          | Items
// ----------+----------------------------------+---------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser | one operation per item
// output    | m_tvalid m_tready m_tdata m_tuser | one result; m_tlast on final of an item
//           | m_tlast                          |
// register  | psel penable pwrite paddr pwdata | grid size registers at 0x0 and 0x4
//           | prdata pready                    |
//
// In the back end a mark reads the slot memory, then writes it and returns the result.
// Scan and clear walk the grid, one slot read per cycle unless a new idle hit waits
// on a held result; a no-op or out-of-range item is answered from the idle state.
// The front register holds each item; a 2-entry queue sits between front and back.
// Synchronous reset clears all slot valid bits at once; no clearing pass.
// A stall on m_tready holds the scan walk; s_tready drops when the queue fills.
`default_nettype none
module tdma_slot_occupancy_table_unit #(
  parameter int MAX_TIMESLOTS = tsot_pkg::DEF_MAX_TIMESLOTS,
  parameter int MAX_FREQSLOTS = tsot_pkg::DEF_MAX_FREQSLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // s_tdata: time_index[7:0], freq_index[15:8], now_ns[78:16], timeout_ms[110:79]
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [tsot_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: operation[3:0]
  input  wire logic [tsot_pkg::S_USER_W-1:0]  s_tuser,
  // m_tdata: prior_state[1:0], changed[2], out_of_range[3], idle_time_index[6:4],
  //          idle_freq_index[9:7]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [tsot_pkg::M_DATA_W-1:0]       m_tdata,
  // m_tuser: idle_valid[0]
  output logic [tsot_pkg::M_USER_W-1:0]       m_tuser,
  output logic                                m_tlast,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tsot_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tsot_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsot_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import tsot_pkg::*;

  logic [CFG_W-1:0]  timeslots_in_use;
  logic [CFG_W-1:0]  freqslots_in_use;
  logic [GRID_W-1:0] grid_t;
  logic [GRID_W-1:0] grid_f;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  cmd_t              q_cmd;
  cmd_t              q_head;
  result_t           res;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeslots_in_use <= '0;
      freqslots_in_use <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TIMESLOTS) timeslots_in_use <= pwdata[CFG_W-1:0];
      if (paddr[2] == REG_FREQSLOTS) freqslots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_FREQSLOTS) begin
      prdata = PDATA_W'(freqslots_in_use);
    end else begin
      prdata = PDATA_W'(timeslots_in_use);
    end
  end

  assign grid_t = grid_size(timeslots_in_use, MAX_TIMESLOTS);
  assign grid_f = grid_size(freqslots_in_use, MAX_FREQSLOTS);

  tsot_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .grid_t   (grid_t),
    .grid_f   (grid_f),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .q_full   (q_full)
  );

  tsot_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tsot_back #(
    .MAX_TIMESLOTS (MAX_TIMESLOTS),
    .MAX_FREQSLOTS (MAX_FREQSLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .grid_t   (grid_t),
    .grid_f   (grid_f),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  // Result packing
  assign m_tdata = {6'b0, res.idle_f, res.idle_t, res.oor, res.changed, res.prior};
  assign m_tuser = res.idle_valid;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

/* sv/tsot_checker.sv */
`default_nettype none
module tsot_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [tsot_pkg::M_DATA_W-1:0] m_tdata,
  input  wire logic [tsot_pkg::M_USER_W-1:0] m_tuser,
  input  wire logic                          m_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output result changed while stalled");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Out-of-range result carries nothing else and ends its item
  a_oor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tlast && !m_tuser[0] && !m_tdata[2] &&
                               (m_tdata[1:0] == 2'd0))
    else $error("out-of-range result malformed");

  // Idle-slot result has no mark fields
  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[3:0] == 4'd0))
    else $error("idle result carries mark fields");

  // Any result that is not an idle slot is the only one of its item
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("non-idle result without last");

endmodule

bind tdma_slot_occupancy_table_unit tsot_checker u_tsot_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
